### hdl/gcge_pkg.sv
// ----------------------------------------------------------------------------
// gcge_pkg
// shared types and constants of the graph cut gain engine
// ----------------------------------------------------------------------------
`default_nettype none

package gcge_pkg;

    // item opcodes
    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_ADD_EDGE  = 3'd1,
        OP_WRITE_S   = 3'd2,
        OP_WRITE_T   = 3'd3,
        OP_CUT       = 3'd4,
        OP_NODE_GAIN = 3'd5,
        OP_SET_GAIN  = 3'd6,
        OP_NONE      = 3'd7
    } op_t;

    // fixed field widths of the item and result ports
    localparam int OP_W     = 3;
    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 16;
    localparam int RESULT_W = 29;

    // query sums saturate to +/- this value
    localparam longint SUM_LIMIT = 64'd268435455;

    // bit positions inside one membership memory entry
    localparam int MEMB_S = 0;
    localparam int MEMB_T = 1;

endpackage

`default_nettype wire

### hdl/graph_cut_gain_engine_core.sv
// ----------------------------------------------------------------------------
// graph_cut_gain_engine_core
// Keeps a store of weighted directed edges and the node sets S and T, and
// answers the directed cut value f(S), the gain of adding one node, and the
// gain of adding T\S. Edge loads, membership writes and unused opcodes
// answer in the cycle after they are accepted. A query reads the edge memory
// one edge per cycle and then the membership memory at both endpoints; a
// node gain first reads the queried node's bit. After reset and after every
// clear item the membership memory is swept to zero, one entry per cycle, and
// the block takes no item until the sweep ends; a clear item answers at the
// end of its sweep. Weights are unsigned 8.8 fixed point and query sums are
// signed 21.8 in 29 bits; sums saturate to +/- 268435455.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_cut_gain_engine_core #(
    parameter int NODES       = 1024,
    parameter int MAX_EDGES   = 4096,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [gcge_pkg::OP_W-1:0]        op,
    input  wire logic [gcge_pkg::NODE_W-1:0]      node_a,
    input  wire logic [gcge_pkg::NODE_W-1:0]      node_b,
    input  wire logic [gcge_pkg::WEIGHT_W-1:0]    weight,
    input  wire logic                             member,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [gcge_pkg::RESULT_W-1:0]  result_value,
    output logic                                  status
);

    import gcge_pkg::*;

    localparam int NA_W   = $clog2(NODES);
    localparam int EC_W   = $clog2(MAX_EDGES + 1);
    localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ED_W   = 2 * NA_W + WEIGHT_BITS;
    localparam int ACC_W  = EC_W + WEIGHT_BITS + 1;
    localparam int SAT_W  = (ACC_W > RESULT_W + 1) ? ACC_W : RESULT_W + 1;

    localparam logic signed [SAT_W-1:0] POS_LIM = SAT_W'(SUM_LIMIT);
    localparam logic signed [SAT_W-1:0] NEG_LIM = -SAT_W'(SUM_LIMIT);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NODE,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    state_t                     state_reg;
    op_t                        q_op_reg;
    logic [NA_W-1:0]            q_node_reg;
    logic                       q_in_s_reg;
    logic                       clr_reply_reg;
    logic [NA_W-1:0]            clr_idx_reg;
    logic [EC_W-1:0]            edge_count_reg;
    logic [EC_W-1:0]            edge_idx_reg;
    logic                       p1_vld_reg;
    logic                       p2_vld_reg;
    logic [NA_W-1:0]            p2_src_reg;
    logic [NA_W-1:0]            p2_dst_reg;
    logic [WEIGHT_BITS-1:0]     p2_w_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       out_valid_reg;
    logic signed [RESULT_W-1:0] result_value_reg;
    logic                       status_reg;

    // memories
    logic [ED_W-1:0]            edge_mem [MAX_EDGES];
    logic [ED_W-1:0]            edge_rd_reg;
    logic [1:0]                 memb_mem [NODES];
    logic [1:0]                 memb_rd_a_reg;
    logic [1:0]                 memb_rd_b_reg;

    logic                       accept;
    op_t                        in_op;
    logic                       node_a_ok;
    logic                       node_b_ok;
    logic [NA_W-1:0]            node_a_idx;
    logic [NA_W-1:0]            node_b_idx;
    logic                       edge_full;
    logic                       edge_we;
    logic [ED_W-1:0]            edge_wdata;
    logic [1:0]                 memb_we;
    logic [NA_W-1:0]            memb_wa;
    logic                       memb_wd;
    logic [NA_W-1:0]            memb_ra;
    logic [NA_W-1:0]            rd_src;
    logic [NA_W-1:0]            rd_dst;
    logic                       s_a;
    logic                       s_b;
    logic                       t_a;
    logic                       t_b;
    logic                       add_w;
    logic                       sub_w;
    logic signed [ACC_W-1:0]    w_ext;
    logic signed [SAT_W-1:0]    acc_wide;
    logic signed [SAT_W-1:0]    acc_sat;
    logic                       sweep_done;

    assign in_ready     = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept       = in_valid && in_ready;
    assign in_op        = op_t'(op);
    assign node_a_ok    = (32'(node_a) < NODES);
    assign node_b_ok    = (32'(node_b) < NODES);
    assign node_a_idx   = NA_W'(node_a);
    assign node_b_idx   = NA_W'(node_b);
    assign edge_full    = (32'(edge_count_reg) >= MAX_EDGES);
    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;

    // edge store write
    assign edge_we    = accept && (in_op == OP_ADD_EDGE) && !edge_full
                        && node_a_ok && node_b_ok;
    assign edge_wdata = {node_a_idx, node_b_idx, WEIGHT_BITS'(weight)};

    // membership write port: clearing sweep or single bit write
    always_comb
    begin
        memb_we = 2'b00;
        memb_wa = node_a_idx;
        memb_wd = member;
        if (state_reg == ST_CLEAR)
        begin
            memb_we = 2'b11;
            memb_wa = clr_idx_reg;
            memb_wd = 1'b0;
        end
        else if (accept && node_a_ok)
        begin
            memb_we[MEMB_S] = (in_op == OP_WRITE_S);
            memb_we[MEMB_T] = (in_op == OP_WRITE_T);
        end
    end

    assign rd_src  = edge_rd_reg[ED_W-1 -: NA_W];
    assign rd_dst  = edge_rd_reg[WEIGHT_BITS +: NA_W];
    assign memb_ra = (state_reg == ST_IDLE) ? node_a_idx : rd_src;

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_count_reg[EA_W-1:0]] <= edge_wdata;
        end
        edge_rd_reg <= edge_mem[edge_idx_reg[EA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (memb_we[MEMB_S])
        begin
            memb_mem[memb_wa][MEMB_S] <= memb_wd;
        end
        if (memb_we[MEMB_T])
        begin
            memb_mem[memb_wa][MEMB_T] <= memb_wd;
        end
        memb_rd_a_reg <= memb_mem[memb_ra];
        memb_rd_b_reg <= memb_mem[rd_dst];
    end

    // per-edge contribution
    always_comb
    begin
        s_a   = memb_rd_a_reg[MEMB_S];
        t_a   = memb_rd_a_reg[MEMB_T];
        s_b   = memb_rd_b_reg[MEMB_S];
        t_b   = memb_rd_b_reg[MEMB_T];
        add_w = 1'b0;
        sub_w = 1'b0;
        unique case (q_op_reg)
            OP_CUT:
            begin
                add_w = s_a && !s_b;
            end
            OP_NODE_GAIN:
            begin
                if (p2_src_reg != p2_dst_reg)
                begin
                    add_w = (p2_src_reg == q_node_reg) && !s_b;
                    sub_w = (p2_dst_reg == q_node_reg) && s_a;
                end
            end
            OP_SET_GAIN:
            begin
                add_w = t_a && !s_a && !s_b && !t_b;
                sub_w = t_b && !s_b && s_a;
            end
            default:
            begin
                add_w = 1'b0;
                sub_w = 1'b0;
            end
        endcase
    end

    assign w_ext = ACC_W'(p2_w_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (p2_vld_reg && add_w)
        begin
            acc_next = acc_reg + w_ext;
        end
        else if (p2_vld_reg && sub_w)
        begin
            acc_next = acc_reg - w_ext;
        end
    end

    // saturation of the final sum
    assign acc_wide = SAT_W'(acc_reg);

    always_comb
    begin
        priority if (acc_wide > POS_LIM)
        begin
            acc_sat = POS_LIM;
        end
        else if (acc_wide < NEG_LIM)
        begin
            acc_sat = NEG_LIM;
        end
        else
        begin
            acc_sat = acc_wide;
        end
    end

    assign sweep_done = (state_reg == ST_DRAIN) && !p1_vld_reg && !p2_vld_reg;

    // sweep pipeline data
    always_ff @(posedge clk)
    begin
        p2_src_reg <= rd_src;
        p2_dst_reg <= rd_dst;
        p2_w_reg   <= edge_rd_reg[WEIGHT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            q_op_reg         <= OP_NONE;
            q_node_reg       <= '0;
            q_in_s_reg       <= 1'b0;
            clr_reply_reg    <= 1'b0;
            clr_idx_reg      <= '0;
            edge_count_reg   <= '0;
            edge_idx_reg     <= '0;
            p1_vld_reg       <= 1'b0;
            p2_vld_reg       <= 1'b0;
            acc_reg          <= '0;
            out_valid_reg    <= 1'b0;
            result_value_reg <= '0;
            status_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            p2_vld_reg <= p1_vld_reg;
            acc_reg    <= acc_next;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + NA_W'(1);
                    if (clr_idx_reg == NA_W'(NODES - 1))
                    begin
                        clr_idx_reg <= '0;
                        state_reg   <= ST_IDLE;
                        if (clr_reply_reg)
                        begin
                            out_valid_reg    <= 1'b1;
                            result_value_reg <= '0;
                            status_reg       <= 1'b0;
                        end
                        clr_reply_reg <= 1'b0;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        q_op_reg     <= in_op;
                        q_node_reg   <= node_a_idx;
                        acc_reg      <= '0;
                        edge_idx_reg <= '0;
                        unique case (in_op)
                            OP_CLEAR:
                            begin
                                edge_count_reg <= '0;
                                clr_reply_reg  <= 1'b1;
                                clr_idx_reg    <= '0;
                                state_reg      <= ST_CLEAR;
                            end
                            OP_CUT, OP_SET_GAIN:
                            begin
                                state_reg <= ST_SWEEP;
                            end
                            OP_NODE_GAIN:
                            begin
                                if (node_a_ok)
                                begin
                                    state_reg <= ST_NODE;
                                end
                                else
                                begin
                                    out_valid_reg    <= 1'b1;
                                    result_value_reg <= '0;
                                    status_reg       <= 1'b0;
                                end
                            end
                            OP_ADD_EDGE:
                            begin
                                if (edge_we)
                                begin
                                    edge_count_reg <= edge_count_reg + EC_W'(1);
                                end
                                out_valid_reg    <= 1'b1;
                                result_value_reg <= '0;
                                status_reg       <= edge_full;
                            end
                            default:
                            begin
                                out_valid_reg    <= 1'b1;
                                result_value_reg <= '0;
                                status_reg       <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_NODE:
                begin
                    q_in_s_reg <= memb_rd_a_reg[MEMB_S];
                    state_reg  <= ST_SWEEP;
                end
                ST_SWEEP:
                begin
                    if (edge_idx_reg < edge_count_reg)
                    begin
                        p1_vld_reg   <= 1'b1;
                        edge_idx_reg <= edge_idx_reg + EC_W'(1);
                    end
                    else
                    begin
                        p1_vld_reg <= 1'b0;
                        state_reg  <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    p1_vld_reg <= 1'b0;
                    if (sweep_done)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= 1'b0;
                        if ((q_op_reg == OP_NODE_GAIN) && q_in_s_reg)
                        begin
                            result_value_reg <= '0;
                        end
                        else
                        begin
                            result_value_reg <= acc_sat[RESULT_W-1:0];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(edge_count_reg) <= MAX_EDGES)
        else $error("edge count beyond store depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_idx_reg <= edge_count_reg)
        else $error("sweep index past edge count");

    a_pipe_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_vld_reg || p2_vld_reg) |-> (state_reg == ST_SWEEP || state_reg == ST_DRAIN))
        else $error("sweep pipeline active outside a query");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_done |-> (!out_valid_reg || out_ready))
        else $error("query result would overwrite a pending transfer");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !(out_valid_reg && $past(!clr_reply_reg)
            && !$past(out_valid_reg)))
        else $error("result produced by the reset clearing sweep");

endmodule

`default_nettype wire
